// ===== rtl/solq_pkg.sv =====
// ---------------------------------------------------------------------------
// Sorted open-list queue package
// Shared constants, operation codes, sequencer states and word types.
// ---------------------------------------------------------------------------
package solq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int ADDR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int COORD_BITS  = 8;
   localparam int KEY_BITS    = 32;
   localparam int POS_BITS    = 6;
   localparam int ENTRY_BITS  = 2 * COORD_BITS + KEY_BITS;

   typedef enum logic [2:0] {
      OP_INSERT = 3'd0,
      OP_PUSH   = 3'd1,
      OP_POP    = 3'd2,
      OP_FIND   = 3'd3,
      OP_REMOVE = 3'd4,
      OP_PEEK   = 3'd5,
      OP_CLEAR  = 3'd6
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_FETCH_CHK,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_PLACE,
      ST_CLOSE_RD,
      ST_CLOSE_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [KEY_BITS-1:0]   key;
   } entry_type;

   typedef struct packed {
      logic [2:0]            op;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [KEY_BITS-1:0]   key;
      logic [POS_BITS-1:0]   position;
   } request_type;

   typedef struct packed {
      logic                  hit;
      entry_type             entry;
      logic [COUNT_BITS-1:0] occupancy;
      logic                  overflow;
   } result_type;

endpackage

// ===== rtl/solq_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module solq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/solq_ctrl.sv =====
// ---------------------------------------------------------------------------
// Sorted open-list queue sequencer
// Scans, shifts and updates the entry store one word per step.
// ---------------------------------------------------------------------------
module solq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  solq_pkg::request_type   req,
   output logic                    ready,
   input  logic                    out_free,
   output logic                    done,
   output solq_pkg::result_type    result,
   output logic                    ram_wr_en,
   output logic [solq_pkg::ADDR_BITS-1:0]  ram_wr_addr,
   output logic [solq_pkg::ENTRY_BITS-1:0] ram_wr_data,
   output logic                    ram_rd_en,
   output logic [solq_pkg::ADDR_BITS-1:0]  ram_rd_addr,
   input  logic [solq_pkg::ENTRY_BITS-1:0] ram_rd_data
);
   import solq_pkg::*;

   state_type             state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] idx_ff, idx_in;
   logic [COUNT_BITS-1:0] pos_ff, pos_in;
   op_type                op_ff, op_in;
   entry_type             new_ff, new_in;
   logic                  hit_ff, hit_in;
   entry_type             res_ff, res_in;
   logic                  ovf_ff, ovf_in;

   entry_type             rd_entry;
   logic [COUNT_BITS-1:0] idx_dec;
   logic [COUNT_BITS-1:0] idx_inc;
   logic [COUNT_BITS-1:0] peek_pos;
   logic                  key_greater;
   logic                  cell_match;

   assign rd_entry    = entry_type'(ram_rd_data);
   assign idx_dec     = idx_ff - COUNT_BITS'(1);
   assign idx_inc     = idx_ff + COUNT_BITS'(1);
   assign peek_pos    = COUNT_BITS'(req.position);
   assign key_greater = rd_entry.key > new_ff.key;
   assign cell_match  = (rd_entry.x == new_ff.x) && (rd_entry.y == new_ff.y);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      op_ff  <= op_in;
      new_ff <= new_in;
      hit_ff <= hit_in;
      res_ff <= res_in;
      ovf_ff <= ovf_in;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      op_in       = op_ff;
      new_in      = new_ff;
      hit_in      = hit_ff;
      res_in      = res_ff;
      ovf_in      = ovf_ff;
      ready       = 1'b0;
      done        = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff[ADDR_BITS-1:0];
      ram_wr_data = ENTRY_BITS'(rd_entry);
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[ADDR_BITS-1:0];

      case (state_ff)
         ST_IDLE: begin
            ready = 1'b1;
            if (start) begin
               op_in     = op_type'(req.op);
               new_in.x  = req.x;
               new_in.y  = req.y;
               new_in.key = req.key;
               hit_in    = 1'b0;
               res_in    = '0;
               ovf_in    = 1'b0;
               idx_in    = '0;
               pos_in    = '0;
               state_in  = ST_DONE;
               case (op_type'(req.op))
                  OP_INSERT: begin
                     if (count_ff == COUNT_BITS'(QUEUE_DEPTH)) begin
                        ovf_in = 1'b1;
                     end else begin
                        state_in = ST_SCAN_RD;
                     end
                  end
                  OP_PUSH: begin
                     new_in.key = '0;
                     if (count_ff == COUNT_BITS'(QUEUE_DEPTH)) begin
                        ovf_in = 1'b1;
                     end else begin
                        idx_in   = count_ff;
                        state_in = ST_SHIFT_RD;
                     end
                  end
                  OP_POP: begin
                     if (count_ff != '0) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        state_in    = ST_FETCH_CHK;
                     end
                  end
                  OP_FIND, OP_REMOVE: begin
                     state_in = ST_SCAN_RD;
                  end
                  OP_PEEK: begin
                     if (peek_pos < count_ff) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = peek_pos[ADDR_BITS-1:0];
                        idx_in      = peek_pos;
                        state_in    = ST_FETCH_CHK;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               if (op_ff == OP_INSERT) begin
                  pos_in   = idx_ff;
                  state_in = ST_SHIFT_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (op_ff == OP_INSERT) begin
               if (key_greater) begin
                  pos_in   = idx_ff;
                  idx_in   = count_ff;
                  state_in = ST_SHIFT_RD;
               end else begin
                  idx_in   = idx_inc;
                  state_in = ST_SCAN_RD;
               end
            end else if (cell_match) begin
               hit_in   = 1'b1;
               res_in   = rd_entry;
               state_in = (op_ff == OP_REMOVE) ? ST_CLOSE_RD : ST_DONE;
            end else begin
               idx_in   = idx_inc;
               state_in = ST_SCAN_RD;
            end
         end
         ST_FETCH_CHK: begin
            hit_in   = 1'b1;
            res_in   = rd_entry;
            state_in = (op_ff == OP_POP) ? ST_CLOSE_RD : ST_DONE;
         end
         ST_SHIFT_RD: begin
            if (idx_ff == pos_ff) begin
               state_in = ST_PLACE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_dec[ADDR_BITS-1:0];
               state_in    = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            ram_wr_en = 1'b1;
            idx_in    = idx_dec;
            state_in  = ST_SHIFT_RD;
         end
         ST_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff[ADDR_BITS-1:0];
            ram_wr_data = ENTRY_BITS'(new_ff);
            count_in    = count_ff + COUNT_BITS'(1);
            state_in    = ST_DONE;
         end
         ST_CLOSE_RD: begin
            if (idx_inc >= count_ff) begin
               count_in = count_ff - COUNT_BITS'(1);
               state_in = ST_DONE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_inc[ADDR_BITS-1:0];
               state_in    = ST_CLOSE_WR;
            end
         end
         ST_CLOSE_WR: begin
            ram_wr_en = 1'b1;
            idx_in    = idx_inc;
            state_in  = ST_CLOSE_RD;
         end
         ST_DONE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign result.hit       = hit_ff;
   assign result.entry     = res_ff;
   assign result.occupancy = count_ff;
   assign result.overflow  = ovf_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(QUEUE_DEPTH))
      else $error("fill count exceeds queue depth");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> !ready)
      else $error("sequencer still ready after taking a word");

   a_done_free: assert property (@(posedge clock) disable iff (reset)
      done |-> out_free)
      else $error("result finished while output register was occupied");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (done && !result.hit) |-> (result.entry == '0))
      else $error("entry fields not zero on a miss");

   a_ovf_no_hit: assert property (@(posedge clock) disable iff (reset)
      done |-> !(result.hit && result.overflow))
      else $error("overflow and hit reported together");

endmodule

// ===== rtl/sorted_open_list_queue.sv =====
// ---------------------------------------------------------------------------
// Sorted open-list queue
// Bounded ordered queue of grid cells with sorted insert, push, pop, find,
// remove, peek and clear, built on one entry RAM and a word-serial sequencer.
// ---------------------------------------------------------------------------
// A word on the req_ channel carries one operation; every accepted word
// produces exactly one word on the rsp_ channel, in order.
// The sequencer touches one stored entry per step, so an operation's length
// depends on the entries it reaches: a scan reads and then checks each entry
// inspected and a shift reads and then writes each entry moved, both bound
// by the single read and single write port of the entry RAM.
// Clear, a dropped insert or push, and a pop or peek that misses go straight
// to the done state; a peek that hits reads one entry, and a pop that hits
// reads the head entry, then shifts each later entry back to close the gap.
// req_stall is high while an operation is in progress. The finished result
// sits in an output register, so the next word is taken while it waits.
// If rsp_stall holds the result, the following operation runs and then
// waits until the output register is free.
// Reset empties the queue at once; stored entries need no clearing.
// ---------------------------------------------------------------------------
module sorted_open_list_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_op,
   input  logic [solq_pkg::COORD_BITS-1:0]   req_cell_x,
   input  logic [solq_pkg::COORD_BITS-1:0]   req_cell_y,
   input  logic [solq_pkg::KEY_BITS-1:0]     req_sort_key,
   input  logic [solq_pkg::POS_BITS-1:0]     req_position,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic [solq_pkg::COORD_BITS-1:0]   rsp_out_x,
   output logic [solq_pkg::COORD_BITS-1:0]   rsp_out_y,
   output logic [solq_pkg::KEY_BITS-1:0]     rsp_out_key,
   output logic [solq_pkg::COUNT_BITS-1:0]   rsp_occupancy,
   output logic                              rsp_overflow
);
   import solq_pkg::*;

   request_type           req;
   result_type            result;
   result_type            rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  ready;
   logic                  start;
   logic                  done;
   logic                  out_free;
   logic                  ram_wr_en;
   logic [ADDR_BITS-1:0]  ram_wr_addr;
   logic [ENTRY_BITS-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [ADDR_BITS-1:0]  ram_rd_addr;
   logic [ENTRY_BITS-1:0] ram_rd_data;

   assign req.op       = req_op;
   assign req.x        = req_cell_x;
   assign req.y        = req_cell_y;
   assign req.key      = req_sort_key;
   assign req.position = req_position;

   assign req_stall = !ready;
   assign start     = req_valid && ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   solq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req         (req),
      .ready       (ready),
      .out_free    (out_free),
      .done        (done),
      .result      (result),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   solq_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_ff.hit;
   assign rsp_out_x     = rsp_ff.entry.x;
   assign rsp_out_y     = rsp_ff.entry.y;
   assign rsp_out_key   = rsp_ff.entry.key;
   assign rsp_occupancy = rsp_ff.occupancy;
   assign rsp_overflow  = rsp_ff.overflow;

endmodule

// ===== tb/solq_checker.sv =====
// ---------------------------------------------------------------------------
// Sorted open-list queue checker
// Watches the request and reply channels of the queue, keeps a shadow copy
// of the stored entries, works out the reply owed for every accepted request
// word and compares each accepted reply word, field by field, with the
// oldest one owed. Reports the number of replies still owed and the number
// of failures to the testbench top.
// ---------------------------------------------------------------------------
module solq_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [2:0]                      req_op,
   input  logic [solq_pkg::COORD_BITS-1:0] req_cell_x,
   input  logic [solq_pkg::COORD_BITS-1:0] req_cell_y,
   input  logic [solq_pkg::KEY_BITS-1:0]   req_sort_key,
   input  logic [solq_pkg::POS_BITS-1:0]   req_position,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic                            rsp_hit,
   input  logic [solq_pkg::COORD_BITS-1:0] rsp_out_x,
   input  logic [solq_pkg::COORD_BITS-1:0] rsp_out_y,
   input  logic [solq_pkg::KEY_BITS-1:0]   rsp_out_key,
   input  logic [solq_pkg::COUNT_BITS-1:0] rsp_occupancy,
   input  logic                            rsp_overflow,
   output int                              pending_count,
   output int                              fail_count
);
   import solq_pkg::*;

   entry_type   shadow_slots [QUEUE_DEPTH];
   int          shadow_fill = 0;
   result_type  reply_fifo [$];
   request_type req_word;
   result_type  got_word;
   result_type  want_word;
   int          reply_errors = 0;

   function automatic result_type step_open_list(request_type w);
      result_type r;
      int         pos;
      int         i;
      r = '0;
      case (w.op)
         OP_INSERT, OP_PUSH: begin
            if (shadow_fill >= QUEUE_DEPTH) begin
               r.overflow = 1'b1;
            end else begin
               pos = 0;
               if (w.op == OP_INSERT) begin
                  while (pos < shadow_fill && shadow_slots[pos].key <= w.key)
                     pos++;
               end
               for (i = shadow_fill; i > pos; i--)
                  shadow_slots[i] = shadow_slots[i-1];
               shadow_slots[pos].x   = w.x;
               shadow_slots[pos].y   = w.y;
               shadow_slots[pos].key = (w.op == OP_INSERT) ? w.key : '0;
               shadow_fill++;
            end
         end
         OP_POP, OP_FIND, OP_REMOVE, OP_PEEK: begin
            if (w.op == OP_POP) begin
               pos = 0;
            end else if (w.op == OP_PEEK) begin
               pos = int'(w.position);
            end else begin
               pos = shadow_fill;
               for (i = shadow_fill - 1; i >= 0; i--) begin
                  if (shadow_slots[i].x == w.x && shadow_slots[i].y == w.y)
                     pos = i;
               end
            end
            if (pos < shadow_fill) begin
               r.hit   = 1'b1;
               r.entry = shadow_slots[pos];
               if (w.op == OP_POP || w.op == OP_REMOVE) begin
                  for (i = pos; i + 1 < shadow_fill; i++)
                     shadow_slots[i] = shadow_slots[i+1];
                  shadow_fill--;
               end
            end
         end
         OP_CLEAR: begin
            shadow_fill = 0;
         end
         default: begin
         end
      endcase
      r.occupancy = COUNT_BITS'(shadow_fill);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         shadow_fill = 0;
         reply_fifo.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_word = {rsp_hit, rsp_out_x, rsp_out_y, rsp_out_key,
                        rsp_occupancy, rsp_overflow};
            if (reply_fifo.size() == 0) begin
               if (reply_errors < 10)
                  $display("unexpected reply word: hit %0d x %0d y %0d key %h",
                           got_word.hit, got_word.entry.x, got_word.entry.y,
                           got_word.entry.key);
               reply_errors++;
            end else begin
               want_word = reply_fifo.pop_front();
               if (got_word.hit !== want_word.hit ||
                   got_word.entry.x !== want_word.entry.x ||
                   got_word.entry.y !== want_word.entry.y ||
                   got_word.entry.key !== want_word.entry.key ||
                   got_word.occupancy !== want_word.occupancy ||
                   got_word.overflow !== want_word.overflow) begin
                  if (reply_errors < 10) begin
                     $display("mismatch: expected hit %0d x %0d y %0d key %h occ %0d ovf %0d",
                              want_word.hit, want_word.entry.x, want_word.entry.y,
                              want_word.entry.key, want_word.occupancy,
                              want_word.overflow);
                     $display("          got hit %0d x %0d y %0d key %h occ %0d ovf %0d",
                              got_word.hit, got_word.entry.x, got_word.entry.y,
                              got_word.entry.key, got_word.occupancy,
                              got_word.overflow);
                  end
                  reply_errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_word = {req_op, req_cell_x, req_cell_y, req_sort_key, req_position};
            reply_fifo.push_back(step_open_list(req_word));
         end
      end
      pending_count <= reply_fifo.size();
      fail_count    <= reply_errors;
   end

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// Sorted open-list queue testbench
// Drives the queue with a short directed sequence covering the empty and
// edge cases, then with random phases that fill, drain and mix operations,
// under bursty request traffic and patterned reply back-pressure. The
// checker beside the block predicts and compares every reply word.
// ---------------------------------------------------------------------------
module tb_top;
   import solq_pkg::*;

   localparam logic [2:0] OP_UNUSED    = 3'd7;
   localparam int         RANDOM_WORDS = 950;
   localparam int         CYCLE_LIMIT  = 1000000;

   typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_kind;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [2:0]            req_op = '0;
   logic [COORD_BITS-1:0] req_cell_x = '0;
   logic [COORD_BITS-1:0] req_cell_y = '0;
   logic [KEY_BITS-1:0]   req_sort_key = '0;
   logic [POS_BITS-1:0]   req_position = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_hit;
   logic [COORD_BITS-1:0] rsp_out_x;
   logic [COORD_BITS-1:0] rsp_out_y;
   logic [KEY_BITS-1:0]   rsp_out_key;
   logic [COUNT_BITS-1:0] rsp_occupancy;
   logic                  rsp_overflow;

   int                    pending_count;
   int                    fail_count;
   int                    cycle_count = 0;
   int                    words_sent = 0;
   int                    burst_left = 0;
   int                    stall_mode = 0;
   int                    stall_left = 0;

   logic [COORD_BITS-1:0] recent_x [16];
   logic [COORD_BITS-1:0] recent_y [16];
   int                    recent_n = 0;
   int                    recent_wr = 0;

   phase_kind             phase;
   int                    phase_len;
   int                    roll;
   int                    idx;
   bit                    first_phase;
   logic [2:0]            op;
   logic [COORD_BITS-1:0] cx;
   logic [COORD_BITS-1:0] cy;
   logic [KEY_BITS-1:0]   key;
   logic [POS_BITS-1:0]   pos;

   sorted_open_list_queue dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_cell_x    (req_cell_x),
      .req_cell_y    (req_cell_y),
      .req_sort_key  (req_sort_key),
      .req_position  (req_position),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_hit       (rsp_hit),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_key   (rsp_out_key),
      .rsp_occupancy (rsp_occupancy),
      .rsp_overflow  (rsp_overflow)
   );

   solq_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_cell_x    (req_cell_x),
      .req_cell_y    (req_cell_y),
      .req_sort_key  (req_sort_key),
      .req_position  (req_position),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_hit       (rsp_hit),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_key   (rsp_out_key),
      .rsp_occupancy (rsp_occupancy),
      .rsp_overflow  (rsp_overflow),
      .pending_count (pending_count),
      .fail_count    (fail_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(16, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_left[2];
      endcase
   end

   task automatic send_word(input logic [2:0] w_op, input logic [COORD_BITS-1:0] w_x,
                            input logic [COORD_BITS-1:0] w_y,
                            input logic [KEY_BITS-1:0] w_key,
                            input logic [POS_BITS-1:0] w_pos);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 12);
         burst_left = $urandom_range(1, 30);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_op       <= w_op;
      req_cell_x   <= w_x;
      req_cell_y   <= w_y;
      req_sort_key <= w_key;
      req_position <= w_pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   task automatic wait_for_replies();
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_word(OP_POP, 8'd0, 8'd0, '0, 6'd0);
      send_word(OP_PEEK, 8'd0, 8'd0, '0, 6'd0);
      send_word(OP_FIND, 8'd0, 8'd0, '0, 6'd0);
      send_word(OP_REMOVE, 8'd0, 8'd0, '0, 6'd0);
      send_word(OP_UNUSED, 8'd0, 8'd0, '0, 6'd0);
      send_word(OP_INSERT, 8'd0, 8'd0, 32'h0000_0000, 6'd0);
      send_word(OP_INSERT, 8'd255, 8'd255, 32'hFFFF_FFFF, 6'd63);
      send_word(OP_INSERT, 8'd1, 8'd2, 32'h0001_0000, 6'd0);
      send_word(OP_INSERT, 8'd3, 8'd4, 32'h0001_0000, 6'd0);
      send_word(OP_INSERT, 8'd1, 8'd2, 32'h0000_8000, 6'd0);
      send_word(OP_PUSH, 8'd5, 8'd6, 32'hDEAD_BEEF, 6'd0);
      send_word(OP_PEEK, 8'd0, 8'd0, '0, 6'd0);
      send_word(OP_PEEK, 8'd0, 8'd0, '0, 6'd5);
      send_word(OP_PEEK, 8'd0, 8'd0, '0, 6'd6);
      send_word(OP_PEEK, 8'd0, 8'd0, '0, 6'd63);
      send_word(OP_FIND, 8'd3, 8'd4, '0, 6'd0);
      send_word(OP_FIND, 8'd9, 8'd9, '0, 6'd0);
      send_word(OP_REMOVE, 8'd1, 8'd2, '0, 6'd0);
      send_word(OP_REMOVE, 8'd1, 8'd2, '0, 6'd0);
      send_word(OP_REMOVE, 8'd1, 8'd2, '0, 6'd0);
      send_word(OP_POP, 8'd0, 8'd0, '0, 6'd0);
      send_word(OP_UNUSED, 8'd255, 8'd255, 32'hFFFF_FFFF, 6'd63);
      send_word(OP_CLEAR, 8'd0, 8'd0, '0, 6'd0);
      send_word(OP_POP, 8'd0, 8'd0, '0, 6'd0);
      send_word(OP_PUSH, 8'd255, 8'd0, 32'hFFFF_FFFF, 6'd0);
      send_word(OP_INSERT, 8'd0, 8'd255, 32'h8000_0000, 6'd0);
      wait_for_replies();

      // The first random phase is long and mostly inserts and pushes, so it tends
      // to fill the queue to its depth and reach the dropped-insert path.
      words_sent  = 0;
      first_phase = 1'b1;
      while (words_sent < RANDOM_WORDS) begin
         phase     = first_phase ? PHASE_FILL : phase_kind'($urandom_range(0, 2));
         phase_len = first_phase ? $urandom_range(80, 110) : $urandom_range(20, 100);
         for (int n = 0; n < phase_len && words_sent < RANDOM_WORDS; n++) begin
            roll = $urandom_range(0, 99);
            case (phase)
               PHASE_FILL: begin
                  if (roll < 60)      op = OP_INSERT;
                  else if (roll < 80) op = OP_PUSH;
                  else if (roll < 88) op = OP_PEEK;
                  else if (roll < 94) op = OP_FIND;
                  else if (roll < 98) op = OP_POP;
                  else                op = OP_REMOVE;
               end
               PHASE_DRAIN: begin
                  if (roll < 35)      op = OP_POP;
                  else if (roll < 65) op = OP_REMOVE;
                  else if (roll < 75) op = OP_FIND;
                  else if (roll < 85) op = OP_PEEK;
                  else if (roll < 95) op = OP_INSERT;
                  else                op = OP_PUSH;
               end
               default: begin
                  if (roll < 22)      op = OP_INSERT;
                  else if (roll < 32) op = OP_PUSH;
                  else if (roll < 47) op = OP_POP;
                  else if (roll < 60) op = OP_FIND;
                  else if (roll < 75) op = OP_REMOVE;
                  else if (roll < 90) op = OP_PEEK;
                  else if (roll < 94) op = OP_CLEAR;
                  else if (roll < 97) op = OP_UNUSED;
                  else                op = OP_INSERT;
               end
            endcase
            if ((op == OP_FIND || op == OP_REMOVE) && recent_n > 0 &&
                $urandom_range(0, 3) != 0) begin
               idx = $urandom_range(0, recent_n - 1);
               cx  = recent_x[idx];
               cy  = recent_y[idx];
            end else if ($urandom_range(0, 1) != 0) begin
               cx = COORD_BITS'($urandom_range(0, 3));
               cy = COORD_BITS'($urandom_range(0, 3));
            end else begin
               cx = COORD_BITS'($urandom);
               cy = COORD_BITS'($urandom);
            end
            case ($urandom_range(0, 4))
               0: key = '0;
               1: key = '1;
               2: key = $urandom_range(0, 3) << 16;
               default: key = $urandom;
            endcase
            pos = ($urandom_range(0, 1) != 0) ? POS_BITS'($urandom_range(0, 7))
                                              : POS_BITS'($urandom_range(0, 63));
            send_word(op, cx, cy, key, pos);
            if (op == OP_INSERT || op == OP_PUSH) begin
               recent_x[recent_wr] = cx;
               recent_y[recent_wr] = cy;
               recent_wr = (recent_wr + 1) % 16;
               if (recent_n < 16) recent_n++;
            end
         end
         if (first_phase || $urandom_range(0, 3) == 0)
            wait_for_replies();
         first_phase = 1'b0;
      end

      wait_for_replies();
      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
